// ===== rtl/nfcr_pkg.sv =====
// shared types and constants of the nfc reader frame receiver
package nfcr_pkg;

  typedef enum logic [9:0] {
    PH_HUNT0     = 10'b00_0000_0001,
    PH_HUNT1     = 10'b00_0000_0010,
    PH_HUNT2     = 10'b00_0000_0100,
    PH_LEN       = 10'b00_0000_1000,
    PH_LCS       = 10'b00_0001_0000,
    PH_SHORTPOST = 10'b00_0010_0000,
    PH_TFI       = 10'b00_0100_0000,
    PH_DATA      = 10'b00_1000_0000,
    PH_DCS       = 10'b01_0000_0000,
    PH_POST      = 10'b10_0000_0000
  } phase_t;

  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_ACK     = 3'd1;
  localparam logic [2:0] KIND_NACK    = 3'd2;
  localparam logic [2:0] KIND_OK      = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HEADER    = 3'd1;
  localparam logic [2:0] ERR_SHORTPOST = 3'd2;
  localparam logic [2:0] ERR_LCS       = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
  localparam logic [2:0] ERR_TFI       = 3'd5;
  localparam logic [2:0] ERR_DCS       = 3'd6;
  localparam logic [2:0] ERR_POST      = 3'd7;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [7:0] TFI_CODE  = 8'hD5;
  localparam logic [7:0] CMD_MASK  = 8'hFE;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] command_code;
    logic [2:0] error_code;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_t;

endpackage

// ===== rtl/nfcr_in_reg.sv =====
// input register stage holding one received byte
module nfcr_in_reg import nfcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       held_valid,
  output logic [7:0] held_byte,
  input  logic       take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ===== rtl/nfcr_parser.sv =====
// frame state machine: decodes one byte per cycle while fire is high and produces at most one result
module nfcr_parser import nfcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] b,
  input  logic [7:0] max_frame_length,
  output step_t      step
);

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] sum_accumulator, sum_accumulator_next;
  logic [7:0] bytes_taken, bytes_taken_next;
  logic [7:0] first_command, first_command_next;
  logic       is_nack, is_nack_next;
  logic [7:0] len_sum;
  logic [7:0] data_sum;
  logic [7:0] taken_p1;
  logic [8:0] taken_p2;

  assign len_sum  = frame_length + b;
  assign data_sum = sum_accumulator + b;
  assign taken_p1 = bytes_taken + 8'd1;
  assign taken_p2 = {1'b0, taken_p1} + 9'd1;

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    sum_accumulator_next = sum_accumulator;
    bytes_taken_next     = bytes_taken;
    first_command_next   = first_command;
    is_nack_next         = is_nack;
    step                 = '0;
    unique case (phase)
      PH_HUNT0: begin
        if (b == BYTE_ZERO) phase_next = PH_HUNT1;
      end
      PH_HUNT1: begin
        if (b != BYTE_ZERO) begin
          phase_next = PH_HUNT0;
          step.emit = 1'b1;
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_HEADER;
        end else begin
          phase_next = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (b != BYTE_FF) begin
          phase_next = PH_HUNT0;
          step.emit = 1'b1;
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_HEADER;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        frame_length_next = b;
        phase_next = PH_LCS;
      end
      PH_LCS: begin
        if (frame_length == BYTE_ZERO && b == BYTE_FF) begin
          is_nack_next = 1'b0;
          phase_next = PH_SHORTPOST;
        end else if (frame_length == BYTE_FF && b == BYTE_ZERO) begin
          is_nack_next = 1'b1;
          phase_next = PH_SHORTPOST;
        end else if (len_sum != BYTE_ZERO || frame_length == BYTE_ZERO) begin
          phase_next = PH_HUNT0;
          step.emit = 1'b1;
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_LCS;
        end else if (frame_length > max_frame_length) begin
          phase_next = PH_HUNT0;
          step.emit = 1'b1;
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_TOO_LONG;
        end else begin
          phase_next = PH_TFI;
        end
      end
      PH_SHORTPOST: begin
        phase_next = PH_HUNT0;
        step.emit = 1'b1;
        if (b != BYTE_ZERO) begin
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_SHORTPOST;
        end else begin
          step.res.kind = is_nack ? KIND_NACK : KIND_ACK;
        end
      end
      PH_TFI: begin
        if (b != TFI_CODE) begin
          phase_next = PH_HUNT0;
          step.emit = 1'b1;
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_TFI;
        end else begin
          sum_accumulator_next = b;
          bytes_taken_next = '0;
          first_command_next = '0;
          phase_next = (frame_length > 8'd1) ? PH_DATA : PH_DCS;
        end
      end
      PH_DATA: begin
        if (bytes_taken == BYTE_ZERO) first_command_next = b;
        sum_accumulator_next = data_sum;
        bytes_taken_next = taken_p1;
        if (taken_p2 >= {1'b0, frame_length}) phase_next = PH_DCS;
        step.emit = 1'b1;
        step.res.kind = KIND_PAYLOAD;
        step.res.data_byte = b;
        step.res.byte_index = bytes_taken;
      end
      PH_DCS: begin
        if (data_sum != BYTE_ZERO) begin
          phase_next = PH_HUNT0;
          step.emit = 1'b1;
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_DCS;
        end else begin
          phase_next = PH_POST;
        end
      end
      PH_POST: begin
        phase_next = PH_HUNT0;
        step.emit = 1'b1;
        if (b != BYTE_ZERO) begin
          step.res.kind = KIND_ERROR;
          step.res.error_code = ERR_POST;
        end else begin
          step.res.kind = KIND_OK;
          step.res.byte_index = bytes_taken;
          step.res.command_code = (bytes_taken != BYTE_ZERO) ?
                                  (first_command & CMD_MASK) : BYTE_ZERO;
        end
      end
      default: begin
        phase_next = PH_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT0;
      frame_length    <= '0;
      sum_accumulator <= '0;
      bytes_taken     <= '0;
      first_command   <= '0;
      is_nack         <= 1'b0;
    end else if (fire) begin
      phase           <= phase_next;
      frame_length    <= frame_length_next;
      sum_accumulator <= sum_accumulator_next;
      bytes_taken     <= bytes_taken_next;
      first_command   <= first_command_next;
      is_nack         <= is_nack_next;
    end
  end

endmodule

// ===== rtl/nfcr_out_reg.sv =====
// result register holding one finished result until the sink takes it
module nfcr_out_reg import nfcr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out,
  output logic    room
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/nfcr_frame_receiver_core.sv =====
// top level of the nfc reader frame receiver
//
// byte-serial receiver for reader controller response frames.
// input channel: in_valid / in_ready carry one received byte (rx_byte) per
// transaction. output channel: out_valid / out_ready carry one result per
// transaction: a payload byte, ack, nack, frame ok or a numbered error.
// many input bytes (preamble, length, checksums) produce no result.
// configuration: cfg_we writes cfg_wdata into max_frame_length; the user must
// write only while the block is idle, which the block itself does not enforce.
// path: a byte accepted into the input register is decoded from it by the frame
// state machine; its result, if any, is loaded into the result register when it has room.
// throughput: one byte per cycle while the result register has room, through the
// frame state machine between the two registers.
// stall: when the sink holds out_ready low with a result waiting, an empty
// input register still takes one more byte, then in_ready drops until the
// result is taken.
// reset (rst, synchronous): both registers empty, frame hunt restarts,
// max_frame_length returns to 121.
module nfc_reader_frame_receiver_core import nfcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index,
  output logic [7:0] command_code,
  output logic [2:0] error_code,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam logic [7:0] MAX_LEN_RESET = 8'd121;

  logic [7:0] max_len;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       room;
  logic       take;
  step_t      step;
  result_t    res_q;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  // a held byte moves on whenever the result register has room for it
  assign take = held_valid && room;

  nfcr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .take       (take)
  );

  nfcr_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .fire             (take),
    .b                (held_byte),
    .max_frame_length (max_len),
    .step             (step)
  );

  // only bytes that produce a result occupy the result register
  nfcr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take && step.emit),
    .res_in    (step.res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q),
    .room      (room)
  );

  assign kind         = res_q.kind;
  assign data_byte    = res_q.data_byte;
  assign byte_index   = res_q.byte_index;
  assign command_code = res_q.command_code;
  assign error_code   = res_q.error_code;

  // error results always carry a code, other results never do
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR |-> error_code != ERR_NONE)
    else $error("error result without error code");

  a_no_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
    else $error("error code on non-error result");

  // frame ok reports the command with bit 0 cleared
  a_cmd_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_OK |-> command_code[0] == 1'b0)
    else $error("command code has bit 0 set");

  // nothing is presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
